### hw/rtl/scs_pkg.sv
`timescale 1ns / 1ps

package scs_pkg;

  // Fixed field widths of the channels.
  localparam int CMD_W    = 2;
  localparam int NBR_W    = 10;
  localparam int POS_W    = 13;
  localparam int VAL_W    = 13;
  localparam int STAT_W   = 2;
  localparam int CCOUNT_W = 11;

  localparam int CCOUNT_RESET = 1024;

  // Default sizes of the stores.
  localparam int MAX_CELLS_DEF = 1024;
  localparam int MAX_FACES_DEF = 4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR       = 2'd0,
    CMD_APPEND      = 2'd1,
    CMD_READ_SORTED = 2'd2,
    CMD_READ_START  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_RANGE  = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_CNT_RD,
    S_CNT_KEY,
    S_CNT_WR,
    S_PFX_RD,
    S_PFX_WR,
    S_SC_RD,
    S_SC_KEY,
    S_SC_WR,
    S_TOTAL,
    S_READ,
    S_RDATA
  } state_t;

endpackage

### hw/rtl/scs_if.sv
`timescale 1ns / 1ps

interface scs_in_if import scs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [NBR_W-1:0]  neighbour_cell;
  logic [POS_W-1:0]  position;

  modport source (output valid, command, neighbour_cell, position, input ready);
  modport sink   (input valid, command, neighbour_cell, position, output ready);
endinterface

interface scs_out_if import scs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  value;
  logic [STAT_W-1:0] status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

interface scs_cfg_if import scs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CCOUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/scs_ram.sv
`timescale 1ns / 1ps

module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sparse_column_sort_and_starts.sv
`timescale 1ns / 1ps

// Collects the neighbour cell of each appended face and answers reads from two
// tables built on demand: the face indices stably sorted by neighbour cell,
// and each cell's start position (entry n holds the face total, where n is
// the smaller of cell_count and MAX_CELLS). Clear and append requests are
// answered straight from the idle state. Once the tables are valid, a read
// passes through S_READ and S_RDATA to the output register; the first read
// after a clear, an append or a cell_count write first runs the build
// sequencer, which zeroes the count buckets, counts the stored faces, forms
// the prefix sums and scatters the face indices. Input is held off during
// the build; configuration writes are taken whenever the block is idle.
module sparse_column_sort_and_starts import scs_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int MAX_FACES = MAX_FACES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  scs_in_if.sink     in_if,
  scs_out_if.source  out_if,
  scs_cfg_if.sink    cfg_if
);

  localparam int CAW = $clog2(MAX_CELLS + 1);  // cell index, 0..n
  localparam int FA  = $clog2(MAX_FACES);      // face address
  localparam int TW  = $clog2(MAX_FACES + 1);  // face count, 0..MAX_FACES

  state_t              state_r, state_nxt;
  logic [CCOUNT_W-1:0] cell_count_r;
  logic                built_r, built_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [TW-1:0]       f_r, f_nxt;
  logic [CAW-1:0]      c_r, c_nxt;
  logic [CAW-1:0]      key_r, key_nxt;
  logic [TW-1:0]       run_r, run_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_value_r, out_value_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  logic [CAW-1:0]   n;
  logic             in_acc, out_free, read_ok;
  logic [CAW-1:0]   key;
  cmd_t             in_cmd;

  // Memory ports.
  logic             nbr_we;
  logic [FA-1:0]    nbr_waddr, nbr_raddr;
  logic [NBR_W-1:0] nbr_wdata, nbr_rdata;
  logic             cnt_we;
  logic [CAW-1:0]   cnt_waddr, cnt_raddr;
  logic [TW-1:0]    cnt_wdata, cnt_rdata;
  logic             cur_we;
  logic [CAW-1:0]   cur_waddr, cur_raddr;
  logic [TW-1:0]    cur_wdata, cur_rdata;
  logic             srt_we;
  logic [FA-1:0]    srt_waddr, srt_raddr;
  logic [FA-1:0]    srt_wdata, srt_rdata;

  scs_ram #(.WIDTH(NBR_W), .DEPTH(MAX_FACES)) u_nbr_ram (
    .clk, .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
    .raddr(nbr_raddr), .rdata(nbr_rdata)
  );

  scs_ram #(.WIDTH(TW), .DEPTH(MAX_CELLS + 1)) u_cnt_ram (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  scs_ram #(.WIDTH(TW), .DEPTH(MAX_CELLS + 1)) u_cur_ram (
    .clk, .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_raddr), .rdata(cur_rdata)
  );

  scs_ram #(.WIDTH(FA), .DEPTH(MAX_FACES)) u_srt_ram (
    .clk, .we(srt_we), .waddr(srt_waddr), .wdata(srt_wdata),
    .raddr(srt_raddr), .rdata(srt_rdata)
  );

  // The effective cell count bounds both the appended cells and the table.
  assign n = (32'(cell_count_r) < MAX_CELLS) ? CAW'(cell_count_r) : CAW'(MAX_CELLS);

  // Sort key of the neighbour just read: faces whose cell has dropped out of
  // range after a lowered cell_count all sort into the bucket at n.
  assign key = (32'(nbr_rdata) < 32'(n)) ? CAW'(nbr_rdata) : n;

  // A new request is taken in the idle state while the output register is empty or emptying.
  assign out_free     = !out_valid_r || out_if.ready;
  assign in_if.ready  = (state_r == S_IDLE) && out_free;
  assign in_acc       = in_if.valid && in_if.ready;
  assign in_cmd       = cmd_t'(in_if.command);
  assign cfg_if.ready = (state_r == S_IDLE);

  assign out_if.valid  = out_valid_r;
  assign out_if.value  = out_value_r;
  assign out_if.status = out_status_r;

  assign read_ok = (cmd_r == CMD_READ_SORTED) ? (32'(pos_r) < 32'(total_r))
                                              : (32'(pos_r) <= 32'(n));

  always_comb begin
    state_nxt      = state_r;
    built_nxt      = built_r;
    total_nxt      = total_r;
    f_nxt          = f_r;
    c_nxt          = c_r;
    key_nxt        = key_r;
    run_nxt        = run_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    nbr_we    = 1'b0;
    nbr_waddr = total_r[FA-1:0];
    nbr_wdata = in_if.neighbour_cell;
    nbr_raddr = f_r[FA-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = c_r;
    cnt_wdata = '0;
    cnt_raddr = c_r;
    cur_we    = 1'b0;
    cur_waddr = c_r;
    cur_wdata = run_r;
    cur_raddr = key;
    srt_we    = 1'b0;
    srt_waddr = cur_rdata[FA-1:0];
    srt_wdata = f_r[FA-1:0];
    srt_raddr = pos_r[FA-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_cmd;
          pos_nxt = in_if.position;
          case (in_cmd)
            CMD_CLEAR: begin
              total_nxt      = '0;
              built_nxt      = 1'b0;
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = STAT_OK;
            end
            CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = '0;
              if ((32'(in_if.neighbour_cell) >= 32'(n)) ||
                  (32'(total_r) >= MAX_FACES)) begin
                out_status_nxt = STAT_REJECT;
              end else begin
                out_status_nxt = STAT_OK;
                nbr_we         = 1'b1;
                total_nxt      = total_r + TW'(1);
                built_nxt      = 1'b0;
              end
            end
            default: begin
              if (built_r) begin
                state_nxt = S_READ;
              end else begin
                c_nxt     = '0;
                state_nxt = S_CLR;
              end
            end
          endcase
        end
      end
      // Zero the count buckets 0..n.
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_wdata = '0;
        c_nxt     = c_r + CAW'(1);
        f_nxt     = '0;
        if (c_r == n) begin
          c_nxt     = '0;
          run_nxt   = '0;
          state_nxt = (total_r == '0) ? S_PFX_RD : S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        state_nxt = S_CNT_KEY;
      end
      S_CNT_KEY: begin
        cnt_raddr = key;
        key_nxt   = key;
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = key_r;
        cnt_wdata = cnt_rdata + TW'(1);
        f_nxt     = f_r + TW'(1);
        state_nxt = (f_nxt == total_r) ? S_PFX_RD : S_CNT_RD;
      end
      // Exclusive prefix sum into both the start table and the cursors.
      S_PFX_RD: begin
        state_nxt = S_PFX_WR;
      end
      S_PFX_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = run_r;
        cur_we    = 1'b1;
        run_nxt   = run_r + cnt_rdata;
        f_nxt     = '0;
        if (c_r == n) begin
          state_nxt = (total_r == '0) ? S_TOTAL : S_SC_RD;
        end else begin
          c_nxt     = c_r + CAW'(1);
          state_nxt = S_PFX_RD;
        end
      end
      S_SC_RD: begin
        state_nxt = S_SC_KEY;
      end
      S_SC_KEY: begin
        key_nxt   = key;
        state_nxt = S_SC_WR;
      end
      S_SC_WR: begin
        srt_we    = (32'(cur_rdata) < MAX_FACES);
        cur_we    = 1'b1;
        cur_waddr = key_r;
        cur_wdata = cur_rdata + TW'(1);
        f_nxt     = f_r + TW'(1);
        state_nxt = (f_nxt == total_r) ? S_TOTAL : S_SC_RD;
      end
      S_TOTAL: begin
        cnt_we    = 1'b1;
        cnt_waddr = n;
        cnt_wdata = total_r;
        built_nxt = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cnt_raddr = CAW'(pos_r);
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        out_valid_nxt = 1'b1;
        if (!read_ok) begin
          out_value_nxt  = '0;
          out_status_nxt = STAT_RANGE;
        end else begin
          out_status_nxt = STAT_OK;
          out_value_nxt  = (cmd_r == CMD_READ_SORTED) ? VAL_W'(srt_rdata)
                                                      : VAL_W'(cnt_rdata);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A cell_count write invalidates the tables.
    if (cfg_if.valid && cfg_if.ready) begin
      built_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      built_r      <= 1'b0;
      total_r      <= '0;
      cell_count_r <= CCOUNT_W'(CCOUNT_RESET);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        cell_count_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    f_r          <= f_nxt;
    c_r          <= c_nxt;
    key_r        <= key_nxt;
    run_r        <= run_nxt;
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // The face count never passes the capacity of the neighbour store.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= MAX_FACES)
    else $error("face total beyond capacity");

  // A table read is only answered from built tables.
  a_read_built: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDATA) |-> built_r)
    else $error("read answered before build");

  // An accepted append that is not rejected adds exactly one face.
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_APPEND) && (out_status_nxt == STAT_OK))
      |=> (total_r == $past(total_r) + TW'(1)))
    else $error("append did not count the face");

endmodule
